// ===== rtl/hslp_pkg.sv =====
`default_nettype none

package hslp_pkg;

    // Parse phases of the status line.
    typedef enum logic [3:0] {
        PH_H      = 4'd0,
        PH_T1     = 4'd1,
        PH_T2     = 4'd2,
        PH_P      = 4'd3,
        PH_SLASH  = 4'd4,
        PH_MAJOR  = 4'd5,
        PH_DOT    = 4'd6,
        PH_MINOR  = 4'd7,
        PH_STATUS = 4'd8,
        PH_TEXT   = 4'd9,
        PH_LF     = 4'd10
    } phase_t;

    // Verdict codes; VERDICT_NONE marks a byte that gives no verdict.
    typedef enum logic [1:0] {
        VERDICT_OK         = 2'd0,
        VERDICT_ERR        = 2'd1,
        VERDICT_INCOMPLETE = 2'd2,
        VERDICT_NONE       = 2'd3
    } verdict_t;

    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam int CODE_W = 10;

    // One input request.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_start;
        logic       line_last;
    } item_t;

    // One result request.
    typedef struct packed {
        logic [CODE_W-1:0] status_code;
        logic              minor_version;
        logic [1:0]        verdict;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/hslp_in_reg.sv =====
`default_nettype none

module hslp_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hslp_pkg::item_t in_item,
    input  wire logic           take,
    output logic                item_valid,
    output hslp_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    hslp_pkg::item_t item_reg;

    // The register may load whenever it is empty or its request moves on.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/hslp_step.sv =====
`default_nettype none

module hslp_step (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire hslp_pkg::item_t item,
    output logic                 res_valid,
    output hslp_pkg::result_t    res
);

    hslp_pkg::phase_t            phase_reg, phase_next, phase_eff;
    logic [1:0]                  count_reg, count_next, count_eff;
    logic [hslp_pkg::CODE_W-1:0] code_reg, code_next, code_eff, code_mul;
    logic                        version_reg, version_next, version_eff;
    logic                        finished_reg, finished_next, finished_eff;
    hslp_pkg::verdict_t          verd;
    logic                        is_digit;
    logic [7:0]                  c;

    assign c        = item.line_byte;
    assign is_digit = (c >= hslp_pkg::CHAR_ZERO) && (c <= hslp_pkg::CHAR_NINE);

    // A line start clears the state before the byte is parsed.
    always_comb
    begin
        if (item.line_start)
        begin
            phase_eff    = hslp_pkg::PH_H;
            count_eff    = 2'd0;
            code_eff     = '0;
            version_eff  = 1'b0;
            finished_eff = 1'b0;
        end
        else
        begin
            phase_eff    = phase_reg;
            count_eff    = count_reg;
            code_eff     = code_reg;
            version_eff  = version_reg;
            finished_eff = finished_reg;
        end
    end

    // Multiply by ten as two shifts and an add, then add the digit.
    assign code_mul = (code_eff << 3) + (code_eff << 1) + {6'd0, c[3:0]};

    // Advance the parser by one byte.
    always_comb
    begin
        verd         = hslp_pkg::VERDICT_NONE;
        phase_next   = phase_eff;
        count_next   = count_eff;
        code_next    = code_eff;
        version_next = version_eff;
        unique case (phase_eff)
            hslp_pkg::PH_H:
            begin
                if (c == hslp_pkg::CHAR_H) phase_next = hslp_pkg::PH_T1;
                else verd = hslp_pkg::VERDICT_ERR;
            end
            hslp_pkg::PH_T1:
            begin
                if (c == hslp_pkg::CHAR_T) phase_next = hslp_pkg::PH_T2;
                else verd = hslp_pkg::VERDICT_ERR;
            end
            hslp_pkg::PH_T2:
            begin
                if (c == hslp_pkg::CHAR_T) phase_next = hslp_pkg::PH_P;
                else verd = hslp_pkg::VERDICT_ERR;
            end
            hslp_pkg::PH_P:
            begin
                if (c == hslp_pkg::CHAR_P) phase_next = hslp_pkg::PH_SLASH;
                else verd = hslp_pkg::VERDICT_ERR;
            end
            hslp_pkg::PH_SLASH:
            begin
                if (c == hslp_pkg::CHAR_SLASH) phase_next = hslp_pkg::PH_MAJOR;
                else verd = hslp_pkg::VERDICT_ERR;
            end
            hslp_pkg::PH_MAJOR:
            begin
                if (is_digit) phase_next = hslp_pkg::PH_DOT;
                else verd = hslp_pkg::VERDICT_ERR;
            end
            hslp_pkg::PH_DOT:
            begin
                if (c == hslp_pkg::CHAR_DOT) phase_next = hslp_pkg::PH_MINOR;
                else verd = hslp_pkg::VERDICT_ERR;
            end
            hslp_pkg::PH_MINOR:
            begin
                if (c == hslp_pkg::CHAR_ZERO || c == hslp_pkg::CHAR_ONE)
                begin
                    version_next = c[0];
                    phase_next   = hslp_pkg::PH_STATUS;
                end
                else
                begin
                    verd = hslp_pkg::VERDICT_ERR;
                end
            end
            hslp_pkg::PH_STATUS:
            begin
                // Spaces are skipped anywhere among the status digits.
                if (c == hslp_pkg::CHAR_SPACE)
                begin
                    verd = hslp_pkg::VERDICT_NONE;
                end
                else if (!is_digit)
                begin
                    verd = hslp_pkg::VERDICT_ERR;
                end
                else
                begin
                    code_next = code_mul;
                    if (count_eff >= 2'd2)
                    begin
                        count_next = 2'd0;
                        phase_next = hslp_pkg::PH_TEXT;
                    end
                    else
                    begin
                        count_next = count_eff + 2'd1;
                    end
                end
            end
            hslp_pkg::PH_TEXT:
            begin
                if (c == hslp_pkg::CHAR_CR) phase_next = hslp_pkg::PH_LF;
                else if (c == hslp_pkg::CHAR_LF) verd = hslp_pkg::VERDICT_OK;
            end
            hslp_pkg::PH_LF:
            begin
                if (c == hslp_pkg::CHAR_LF) verd = hslp_pkg::VERDICT_OK;
                else verd = hslp_pkg::VERDICT_ERR;
            end
            default:
            begin
                verd = hslp_pkg::VERDICT_ERR;
            end
        endcase
    end

    // Decide whether this byte gives a verdict and build the result.
    always_comb
    begin
        res_valid         = 1'b0;
        finished_next     = finished_eff;
        res.verdict       = verd;
        res.minor_version = version_next;
        res.status_code   = (phase_next == hslp_pkg::PH_TEXT || phase_next == hslp_pkg::PH_LF)
                            ? code_next : '0;
        if (!finished_eff)
        begin
            if (verd != hslp_pkg::VERDICT_NONE)
            begin
                res_valid     = 1'b1;
                finished_next = 1'b1;
            end
            else if (item.line_last)
            begin
                res_valid     = 1'b1;
                finished_next = 1'b1;
                res.verdict   = hslp_pkg::VERDICT_INCOMPLETE;
            end
        end
    end

    // Once finished, the parse state only changes through a line start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= hslp_pkg::PH_H;
            count_reg    <= 2'd0;
            code_reg     <= '0;
            version_reg  <= 1'b0;
            finished_reg <= 1'b0;
        end
        else if (step_en)
        begin
            finished_reg <= finished_next;
            if (finished_eff)
            begin
                phase_reg   <= phase_eff;
                count_reg   <= count_eff;
                code_reg    <= code_eff;
                version_reg <= version_eff;
            end
            else
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                code_reg    <= code_next;
                version_reg <= version_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/http_status_line_parser.sv =====
// HTTP response status line parser.
// Bytes arrive on the s_axis channel, one per request: tdata carries the byte,
// tuser marks the first byte of a new line (the parser restarts) and tlast the
// final byte of the buffer. Each line yields at most one verdict request on
// m_axis: ok, syntax error, or incomplete when the buffer ends first. The
// verdict carries the minor version and, once all three digits are in, the
// status code. Bytes after a verdict are dropped until the next line start.
// A byte is held in an input register and parsed from there by a
// combinational state update; its verdict is loaded into the output register
// as the byte leaves the input register, which it does only while the output
// register is empty or m_axis_tready is high. One byte is taken every cycle
// under that condition. A verdict waiting in the output register blocks only
// the byte behind it, and s_axis_tready falls once that byte is held as well.
// Reset empties both registers and returns the parser to expecting 'H'.
// While m_axis_tready is low the verdict is held stable on m_axis.
`default_nettype none

module http_status_line_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] line_byte
    input  wire logic        s_axis_tuser,   // [0] line_start
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [1:0] verdict, [2] minor_version,
                                             // [12:3] status_code, [15:13] zero
);

    hslp_pkg::item_t   in_item;
    hslp_pkg::item_t   item;
    logic              item_valid;
    logic              advance;
    logic              res_valid;
    hslp_pkg::result_t res;
    hslp_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign in_item.line_byte  = s_axis_tdata;
    assign in_item.line_start = s_axis_tuser;
    assign in_item.line_last  = s_axis_tlast;

    // The held byte is parsed once the output register has room for its verdict.
    assign advance = item_valid && (!out_valid_reg || m_axis_tready);

    hslp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hslp_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register for the verdict request.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_reg.status_code, out_reg.minor_version, out_reg.verdict};

endmodule

`default_nettype wire

// ===== tb/tb_http_status_line_parser.sv =====
module tb_http_status_line_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int DEC_BASE      = 10;
    localparam int HOLD_CYCLES   = 120;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 215;
    localparam int FLOOD_ITEMS   = 40;

    // One pending byte for the driver; settle makes the driver wait until no
    // verdict is outstanding before offering it.
    typedef struct {
        logic [7:0] octet;
        logic       restart;
        logic       tail;
        bit         settle;
    } line_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] line_byte
    logic        s_axis_tuser = 1'b0;    // [0] line_start
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [1:0] verdict, [2] minor_version,
                                         // [12:3] status_code, [15:13] zero

    line_byte_t          pending_bytes[$];
    hslp_pkg::result_t   verdicts_due[$];
    int                  mismatches = 0;
    int                  bytes_queued = 0;
    int                  sender_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_requests = 0;
    int                  holds_served = 0;
    int                  hold_left = 0;
    int                  quiet_cycles = 0;

    // Predicted parser state.
    hslp_pkg::phase_t    prs_phase;
    logic [1:0]          prs_digits;
    logic [9:0]          prs_code;
    logic                prs_minor;
    logic                prs_done;

    http_status_line_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
        mismatches++;
    endtask

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= hslp_pkg::CHAR_ZERO) && (c <= hslp_pkg::CHAR_NINE);
    endfunction

    task automatic clear_parse_state();
        prs_phase  = hslp_pkg::PH_H;
        prs_digits = 2'd0;
        prs_code   = 10'd0;
        prs_minor  = 1'b0;
        prs_done   = 1'b0;
    endtask

    // Advances the predicted parser by one accepted byte and records the
    // verdict that it causes, if any.
    task automatic predict_verdict(input logic [7:0] c, input logic restart,
                                   input logic tail);
        hslp_pkg::verdict_t v;
        int                 acc;
        hslp_pkg::result_t  r;
        if (restart)
            clear_parse_state();
        if (prs_done)
            return;
        v = hslp_pkg::VERDICT_NONE;
        case (prs_phase)
            hslp_pkg::PH_H:
                if (c != hslp_pkg::CHAR_H) v = hslp_pkg::VERDICT_ERR;
                else prs_phase = hslp_pkg::PH_T1;
            hslp_pkg::PH_T1:
                if (c != hslp_pkg::CHAR_T) v = hslp_pkg::VERDICT_ERR;
                else prs_phase = hslp_pkg::PH_T2;
            hslp_pkg::PH_T2:
                if (c != hslp_pkg::CHAR_T) v = hslp_pkg::VERDICT_ERR;
                else prs_phase = hslp_pkg::PH_P;
            hslp_pkg::PH_P:
                if (c != hslp_pkg::CHAR_P) v = hslp_pkg::VERDICT_ERR;
                else prs_phase = hslp_pkg::PH_SLASH;
            hslp_pkg::PH_SLASH:
                if (c != hslp_pkg::CHAR_SLASH) v = hslp_pkg::VERDICT_ERR;
                else prs_phase = hslp_pkg::PH_MAJOR;
            hslp_pkg::PH_MAJOR:
                if (!is_digit(c)) v = hslp_pkg::VERDICT_ERR;
                else prs_phase = hslp_pkg::PH_DOT;
            hslp_pkg::PH_DOT:
                if (c != hslp_pkg::CHAR_DOT) v = hslp_pkg::VERDICT_ERR;
                else prs_phase = hslp_pkg::PH_MINOR;
            hslp_pkg::PH_MINOR:
            begin
                if (c == hslp_pkg::CHAR_ZERO || c == hslp_pkg::CHAR_ONE)
                begin
                    prs_minor = (c == hslp_pkg::CHAR_ONE);
                    prs_phase = hslp_pkg::PH_STATUS;
                end
                else
                    v = hslp_pkg::VERDICT_ERR;
            end
            hslp_pkg::PH_STATUS:
            begin
                // Spaces are skipped anywhere among the status digits.
                if (c == hslp_pkg::CHAR_SPACE)
                    v = hslp_pkg::VERDICT_NONE;
                else if (!is_digit(c))
                    v = hslp_pkg::VERDICT_ERR;
                else
                begin
                    acc = int'(prs_code) * DEC_BASE + int'(c - hslp_pkg::CHAR_ZERO);
                    prs_code = acc[9:0];
                    if (prs_digits >= 2'd2)
                    begin
                        prs_digits = 2'd0;
                        prs_phase  = hslp_pkg::PH_TEXT;
                    end
                    else
                        prs_digits = prs_digits + 2'd1;
                end
            end
            hslp_pkg::PH_TEXT:
            begin
                if (c == hslp_pkg::CHAR_CR)
                    prs_phase = hslp_pkg::PH_LF;
                else if (c == hslp_pkg::CHAR_LF)
                    v = hslp_pkg::VERDICT_OK;
            end
            hslp_pkg::PH_LF:
                v = (c == hslp_pkg::CHAR_LF) ? hslp_pkg::VERDICT_OK : hslp_pkg::VERDICT_ERR;
            default:
                v = hslp_pkg::VERDICT_ERR;
        endcase
        if (v == hslp_pkg::VERDICT_NONE && tail)
            v = hslp_pkg::VERDICT_INCOMPLETE;
        if (v != hslp_pkg::VERDICT_NONE)
        begin
            prs_done        = 1'b1;
            r.verdict       = v;
            r.minor_version = prs_minor;
            r.status_code   = (prs_phase == hslp_pkg::PH_TEXT || prs_phase == hslp_pkg::PH_LF)
                              ? prs_code : '0;
            verdicts_due.push_back(r);
        end
    endtask

    task automatic queue_byte(input logic [7:0] c, input logic restart, input logic tail,
                              input bit settle = 1'b0);
        line_byte_t b;
        b.octet   = c;
        b.restart = restart;
        b.tail    = tail;
        b.settle  = settle;
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Builds one status line, often well formed with random content, and sometimes
    // corrupted, followed by stray bytes, cut short, marked last early, or plain noise.
    task automatic queue_random_line();
        logic [7:0] text[$];
        logic [7:0] c;
        int         shape;
        int         n;
        int         cut;
        bit         mark_tail;
        shape = $urandom_range(99);
        if (shape < 10)
        begin
            // Noise: a few random bytes.
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
                text.push_back(8'($urandom_range(255)));
        end
        else
        begin
            text = {hslp_pkg::CHAR_H, hslp_pkg::CHAR_T, hslp_pkg::CHAR_T, hslp_pkg::CHAR_P,
                    hslp_pkg::CHAR_SLASH};
            text.push_back(hslp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
            text.push_back(hslp_pkg::CHAR_DOT);
            if ($urandom_range(19) == 0)
                text.push_back(8'($urandom_range(255)));
            else
                text.push_back(hslp_pkg::CHAR_ZERO + 8'($urandom_range(1)));
            n = $urandom_range(2);
            for (int i = 0; i < n; i++)
                text.push_back(hslp_pkg::CHAR_SPACE);
            for (int i = 0; i < 3; i++)
            begin
                text.push_back(hslp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                if ($urandom_range(7) == 0)
                    text.push_back(hslp_pkg::CHAR_SPACE);
            end
            n = $urandom_range(6);
            for (int i = 0; i < n; i++)
            begin
                c = 8'($urandom_range(255));
                text.push_back((c == hslp_pkg::CHAR_CR || c == hslp_pkg::CHAR_LF)
                               ? hslp_pkg::CHAR_SPACE : c);
            end
            case ($urandom_range(2))
                0: text.push_back(hslp_pkg::CHAR_LF);
                1: text = {text, hslp_pkg::CHAR_CR, hslp_pkg::CHAR_LF};
                default:
                begin
                    // Carriage return followed by something other than LF.
                    c = 8'($urandom_range(255));
                    text = {text, hslp_pkg::CHAR_CR,
                            (c == hslp_pkg::CHAR_LF) ? hslp_pkg::CHAR_H : c};
                end
            endcase
            if (shape < 25)
                text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
            else if (shape < 30)
                for (int i = 0; i < 3; i++)
                    text.push_back(8'($urandom_range(255)));
        end

        // Where the line ends and whether its final byte carries last.
        cut = text.size();
        mark_tail = ($urandom_range(6) == 0);
        if (shape >= 30 && shape < 42)
        begin
            cut = $urandom_range(text.size(), 1);
            mark_tail = 1'b1;
        end
        else if (shape >= 42 && shape < 47)
        begin
            cut = $urandom_range(text.size(), 1);
            mark_tail = 1'b0;
        end
        for (int i = 0; i < cut; i++)
            queue_byte(text[i], (i == 0) && ($urandom_range(19) != 0),
                       (i == cut - 1) && mark_tail);
    endtask

    task automatic wait_for_driver();
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Driver: offers pending bytes and feeds every accepted one to the
    // predictor.
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        bit         fire;
        bit         offer;
        line_byte_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire)
                predict_verdict(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (!s_axis_tvalid || fire)
            begin
                offer = 1'b0;
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                    offer = !pending_bytes[0].settle || verdicts_due.size() == 0;
                if (offer)
                begin
                    nxt = pending_bytes.pop_front();
                    s_axis_tdata <= nxt.octet;
                    s_axis_tuser <= nxt.restart;
                    s_axis_tlast <= nxt.tail;
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    // Monitor: checks each verdict request against the oldest prediction and
    // drives the receiver's ready, including the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : verdict_monitor
        hslp_pkg::result_t got;
        hslp_pkg::result_t want;
        bit                ready;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[12:0];
                if (verdicts_due.size() == 0)
                    report_mismatch("verdict with none predicted", 0, m_axis_tdata);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (got.verdict != want.verdict)
                        report_mismatch("verdict", want.verdict, got.verdict);
                    if (got.minor_version != want.minor_version)
                        report_mismatch("minor_version", want.minor_version,
                                        got.minor_version);
                    if (got.status_code != want.status_code)
                        report_mismatch("status_code", want.status_code, got.status_code);
                    if (m_axis_tdata[15:13] != 3'b000)
                        report_mismatch("padding bits", 0, m_axis_tdata[15:13]);
                end
            end
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready = 1'b0;
            end
            else
                ready = ($urandom_range(99) >= recv_stall_pct);
            m_axis_tready <= ready;
        end
    end

    // Watchdog: ends the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("http_status_line_parser verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        clear_parse_state();

        // Directed: spaces between digits, bare LF, highest major digit.
        queue_byte(hslp_pkg::CHAR_H, 1'b1, 1'b0);
        queue_byte(hslp_pkg::CHAR_T, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_T, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_P, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_SLASH, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_NINE, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_DOT, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_ONE, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_SPACE, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_NINE, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_SPACE, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_NINE, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_SPACE, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_NINE, 1'b0, 1'b0);
        queue_byte(hslp_pkg::CHAR_LF, 1'b0, 1'b0);
        // Start and last on one byte: incomplete.
        queue_byte(hslp_pkg::CHAR_H, 1'b1, 1'b1);
        // Highest byte is an error; a last byte after it is ignored.
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(hslp_pkg::CHAR_H, 1'b0, 1'b1);
        // Error on the second byte.
        queue_byte(hslp_pkg::CHAR_H, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        // Lowest byte with start and last.
        queue_byte(8'h00, 1'b1, 1'b1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Random phases with different idling on each side.
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_for_driver();
            @(negedge clk);
            sender_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 8) : 0;
            recv_stall_pct  = (ph == 2 || ph == 3) ? ((ph == 2) ? 74 : 8) : 0;
            bytes_queued = 0;
            while (bytes_queued < PHASE_ITEMS)
                queue_random_line();
        end

        // Long receiver hold-off while the sender keeps offering bytes that
        // each produce a verdict, so the block fills and stalls its input.
        wait_for_driver();
        @(negedge clk);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_requests++;
        for (int i = 0; i < FLOOD_ITEMS; i++)
            queue_byte(8'($urandom_range(255)) & 8'h3F, 1'b1, 1'($urandom_range(1)));

        // The next line waits until every verdict so far has been taken.
        queue_byte(hslp_pkg::CHAR_H, 1'b1, 1'b0, 1'b1);
        queue_byte(hslp_pkg::CHAR_T, 1'b0, 1'b1);

        wait_for_driver();
        while (s_axis_tvalid || verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("http_status_line_parser verification clean");
        else
            $display("http_status_line_parser verification failed");
        $finish;
    end

endmodule
